FILE: src/pmcg_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the pose motion continuity gate.
package pmcg_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

    // Register reset values, rounded to the Q format.
    localparam logic [63:0] RST_MAX_SPEED  = ((64'd3   << FRAC_BITS) + 64'd1)  / 64'd2;
    localparam logic [63:0] RST_MAX_ACCEL  = ((64'd6   << FRAC_BITS) + 64'd2)  / 64'd5;
    localparam logic [63:0] RST_MIN_SJUMP  = ((64'd3   << FRAC_BITS) + 64'd5)  / 64'd10;
    localparam logic [63:0] RST_MAX_YRATE  = (64'd80  << FRAC_BITS);
    localparam logic [63:0] RST_MAX_YACCEL = (64'd180 << FRAC_BITS);
    localparam logic [63:0] RST_MIN_YJUMP  = (64'd18  << FRAC_BITS);
    localparam logic [63:0] RST_MAX_CJUMP  = ((64'd9   << FRAC_BITS) + 64'd2)  / 64'd5;
    localparam logic [63:0] RST_MIN_CDIST  = ((64'd1   << FRAC_BITS) + 64'd5)  / 64'd10;

    // Gates on the curvature jump test: more than one degree, more than 3 cm.
    localparam logic [63:0] DEG_MIN = ONE_Q;
    localparam logic [63:0] DS_MIN  = ((64'd3 << FRAC_BITS) + 64'd50) / 64'd100;

    localparam logic [47:0] DT_MIN_US = 48'd1000;
    localparam logic [34:0] US_PER_S  = 35'd1000000;
    localparam logic [34:0] PI_Q33    = 35'h6487ED511;

    // Configuration register indexes.
    localparam logic [7:0] REG_MAX_SPEED  = 8'd0;
    localparam logic [7:0] REG_MAX_ACCEL  = 8'd1;
    localparam logic [7:0] REG_MIN_SJUMP  = 8'd2;
    localparam logic [7:0] REG_MAX_YRATE  = 8'd3;
    localparam logic [7:0] REG_MAX_YACCEL = 8'd4;
    localparam logic [7:0] REG_MIN_YJUMP  = 8'd5;
    localparam logic [7:0] REG_MAX_CJUMP  = 8'd6;
    localparam logic [7:0] REG_MIN_CDIST  = 8'd7;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

endpackage

FILE: src/pmcg_mul.sv
`timescale 1ns / 1ps
// Registered multiplier shared by all products of the gate.
module pmcg_mul (
    input  logic        i_clk,
    input  logic [32:0] i_a,
    input  logic [34:0] i_b,
    output logic [67:0] o_prod
);

    logic [67:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 68'(i_a) * 68'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: src/pmcg_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle, quotient saturated to 32 bits.
module pmcg_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [63:0]         i_num,
    input  logic [47:0]         i_den,
    output pmcg_pkg::t_div_stat o_stat,
    output logic [31:0]         o_quot
);

    logic        r_busy;
    logic        r_done;
    logic        r_ovf;
    logic [4:0]  r_cnt;
    logic [47:0] r_rem;
    logic [47:0] r_den;
    logic [31:0] r_num;
    logic [31:0] r_quot;

    logic        w_ovf;
    logic [48:0] w_sh;
    logic        w_ge;
    logic [48:0] w_diff;

    // A quotient of 2^32 or more shows at once against the shifted divisor.
    assign w_ovf  = {16'd0, i_num} >= {i_den, 32'd0};
    assign w_sh   = {r_rem, r_num[31]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_den <= i_den;
            r_cnt <= 5'd0;
            if (w_ovf) begin
                r_quot <= '1;
                r_ovf  <= 1'b1;
                r_done <= 1'b1;
                r_busy <= 1'b0;
            end else begin
                r_rem  <= i_num[63:32];
                r_num  <= i_num[31:0];
                r_ovf  <= 1'b0;
                r_done <= 1'b0;
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[47:0] : w_sh[47:0];
            r_num  <= {r_num[30:0], 1'b0};
            r_quot <= {r_quot[30:0], w_ge};
            r_cnt  <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;
    assign o_quot      = r_quot;

endmodule

FILE: src/pmcg_sqrt.sv
`timescale 1ns / 1ps
// Bit-pair integer square root of a 64-bit value, one root bit a cycle.
module pmcg_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_val;
    logic [33:0] r_rem;
    logic [31:0] r_root;

    logic [35:0] w_rem2;
    logic [35:0] w_trial;
    logic        w_ge;
    logic [35:0] w_diff;

    assign w_rem2  = {r_rem, r_val[63:62]};
    assign w_trial = {2'd0, r_root, 2'b01};
    assign w_ge    = w_rem2 >= w_trial;
    assign w_diff  = w_rem2 - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_val  <= i_val;
            r_rem  <= 34'd0;
            r_root <= 32'd0;
            r_cnt  <= 5'd0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[33:0] : w_rem2[33:0];
            r_root <= {r_root[30:0], w_ge};
            r_val  <= {r_val[61:0], 2'b00};
            r_cnt  <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: src/pose_motion_continuity_gate.sv
`timescale 1ns / 1ps
// Top level of the pose motion continuity gate: sequencer, state and result register.
//
// The gate takes one pose beat at a time and answers each with exactly one
// result beat. An evaluate beat compares the candidate pose with the last
// committed pose and the newest committed motion sample; a valid commit beat
// stores the pose and, when a previous pose existed, the new motion sample.
// The input side stalls from the accepted beat until its result has been
// loaded into the output register, so the output may still be waiting while
// the next pose is taken. A pose that needs no motion (invalid pose, or no
// last pose) goes from the preparation state straight to the done state,
// where its result is loaded. A motion pass runs one square root for the
// distance and three or five divisions (speed, yaw rate, curvature, and
// both accelerations: all five only for an evaluate with history), and
// the finished result may then wait on a stalled output register. The
// divisions run one after another on a single shared divider, with a
// single registered multiplier feeding the products. Each root or
// division holds the sequencer in its wait state until it reports done; the
// divider finishes at once when it sees that the quotient saturates.
// Configuration writes are always ready and must only be made while the gate
// is idle; unknown register indexes are ignored.
module pose_motion_continuity_gate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pose channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic        i_pose_valid,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [15:0] i_heading,
    input  logic [47:0] i_time_us,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_continuous,
    output logic        o_ready_res,
    output logic [31:0] o_speed,
    output logic [31:0] o_yaw_rate,
    output logic [31:0] o_curvature,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Sequencer states.
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_PREP   = 5'd1;
    localparam logic [4:0] ST_MSQX   = 5'd2;
    localparam logic [4:0] ST_MSQY   = 5'd3;
    localparam logic [4:0] ST_MRAD   = 5'd4;
    localparam logic [4:0] ST_SQGO   = 5'd5;
    localparam logic [4:0] ST_SQW    = 5'd6;
    localparam logic [4:0] ST_MSPD   = 5'd7;
    localparam logic [4:0] ST_DSPDGO = 5'd8;
    localparam logic [4:0] ST_DSPDW  = 5'd9;
    localparam logic [4:0] ST_MYAW   = 5'd10;
    localparam logic [4:0] ST_DYAWGO = 5'd11;
    localparam logic [4:0] ST_DYAWW  = 5'd12;
    localparam logic [4:0] ST_DCRVGO = 5'd13;
    localparam logic [4:0] ST_DCRVW  = 5'd14;
    localparam logic [4:0] ST_MACC   = 5'd15;
    localparam logic [4:0] ST_DACCGO = 5'd16;
    localparam logic [4:0] ST_DACCW  = 5'd17;
    localparam logic [4:0] ST_MYAC   = 5'd18;
    localparam logic [4:0] ST_DYACGO = 5'd19;
    localparam logic [4:0] ST_DYACW  = 5'd20;
    localparam logic [4:0] ST_DONE   = 5'd21;

    localparam int RAD_SHIFT = 48 - pmcg_pkg::FRAC_BITS;

    logic [4:0]  r_state;
    logic [4:0]  n_state;

    // Configuration registers.
    logic [31:0] r_max_speed;
    logic [31:0] r_max_accel;
    logic [31:0] r_min_sjump;
    logic [31:0] r_max_yrate;
    logic [31:0] r_max_yaccel;
    logic [31:0] r_min_yjump;
    logic [31:0] r_max_cjump;
    logic [31:0] r_min_cdist;

    // Committed pose and newest motion sample.
    logic [31:0] r_last_x;
    logic [31:0] r_last_y;
    logic [15:0] r_last_hdg;
    logic [47:0] r_last_time;
    logic        r_has_last;
    logic        r_has_hist;
    logic [31:0] r_hist_spd;
    logic [31:0] r_hist_yaw;
    logic [31:0] r_hist_crv;

    // Beat under work.
    logic        r_req;
    logic        r_valid;
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [15:0] r_hdg;
    logic [47:0] r_time;

    // Working values.
    logic [31:0] r_bx;
    logic [31:0] r_by;
    logic        r_half;
    logic [15:0] r_d;
    logic [31:0] r_deg;
    logic [47:0] r_dt;
    logic [63:0] r_sum;
    logic [31:0] r_rad;
    logic [32:0] r_ds;
    logic [31:0] r_speed;
    logic [31:0] r_yaw;
    logic [31:0] r_curv;
    logic        r_acc_gt;
    logic        r_yacc_gt;

    // Result register.
    logic        r_ov;
    logic        r_o_cont;
    logic        r_o_rdy;
    logic [31:0] r_o_spd;
    logic [31:0] r_o_yaw;
    logic [31:0] r_o_crv;

    // Shared units.
    logic [32:0]          w_mul_a;
    logic [34:0]          w_mul_b;
    logic [67:0]          w_prod;
    logic                 w_div_start;
    logic [63:0]          w_div_num;
    logic [47:0]          w_div_den;
    pmcg_pkg::t_div_stat  w_div_stat;
    logic [31:0]          w_quot;
    logic                 w_sq_start;
    logic                 w_sq_done;
    logic [31:0]          w_root;

    // Preparation terms.
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic [32:0]        w_ax;
    logic [32:0]        w_ay;
    logic               w_half;
    logic [15:0]        w_hd;
    logic [15:0]        w_d;
    logic [63:0]        w_deg64;
    logic [47:0]        w_tdiff;
    logic               w_use_diff;
    logic [32:0]        w_cden;

    // Decision terms.
    logic [31:0] w_sj;
    logic [31:0] w_yj;
    logic [31:0] w_cj;
    logic        w_bad;
    logic        w_in_acc;
    logic        w_load;
    logic        w_motion;
    logic        w_commit_ok;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Differences against the last committed pose. Wide moves are halved
    // before squaring and the root is doubled afterwards.
    assign w_dx   = $signed({r_x[31], r_x}) - $signed({r_last_x[31], r_last_x});
    assign w_dy   = $signed({r_y[31], r_y}) - $signed({r_last_y[31], r_last_y});
    assign w_ax   = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
    assign w_ay   = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
    assign w_half = w_ax[32] | w_ax[31] | w_ay[32] | w_ay[31];

    // Heading change wrapped into half a circle.
    assign w_hd    = r_hdg - r_last_hdg;
    assign w_d     = (w_hd > 16'd32768) ? 16'(17'd65536 - 17'(w_hd)) : w_hd;
    assign w_deg64 = ((64'(w_d) * 64'd360) << pmcg_pkg::FRAC_BITS) >> 16;

    // Time step, floored at one millisecond. An evaluate also needs a
    // nonzero last time before the real step is used.
    assign w_tdiff    = r_time - r_last_time;
    assign w_use_diff = (r_time > r_last_time) && (w_tdiff > pmcg_pkg::DT_MIN_US)
                        && (r_req || (r_last_time != 48'd0));

    // Curvature divisor: the larger of distance and floor, at least one LSB.
    always_comb begin
        w_cden = (r_ds > {1'b0, r_min_cdist}) ? r_ds : {1'b0, r_min_cdist};
        if (w_cden == 33'd0) begin
            w_cden = 33'd1;
        end
    end

    assign w_sj = (r_speed > r_hist_spd) ? r_speed - r_hist_spd : r_hist_spd - r_speed;
    assign w_yj = (r_yaw > r_hist_yaw) ? r_yaw - r_hist_yaw : r_hist_yaw - r_yaw;
    assign w_cj = (r_curv > r_hist_crv) ? r_curv - r_hist_crv : r_hist_crv - r_curv;

    assign w_bad = (r_speed > r_max_speed)
                   || (r_acc_gt && (w_sj > r_min_sjump))
                   || (r_yaw > r_max_yrate)
                   || (r_yacc_gt && (w_yj > r_min_yjump))
                   || ((w_cj > r_max_cjump) && (64'(r_deg) > pmcg_pkg::DEG_MIN)
                       && (64'(r_ds) > pmcg_pkg::DS_MIN));

    assign w_motion    = r_valid && r_has_last;
    assign w_commit_ok = r_req && r_valid;
    assign w_load      = (r_state == ST_DONE) && (!r_ov || !i_out_stall);

    // Multiplier operands by sequencer step.
    always_comb begin
        case (r_state)
            ST_MSQX: begin
                w_mul_a = {1'b0, r_bx};
                w_mul_b = {3'd0, r_bx};
            end
            ST_MSQY: begin
                w_mul_a = {1'b0, r_by};
                w_mul_b = {3'd0, r_by};
            end
            ST_MRAD: begin
                w_mul_a = 33'(r_d);
                w_mul_b = pmcg_pkg::PI_Q33;
            end
            ST_MSPD: begin
                w_mul_a = r_ds;
                w_mul_b = pmcg_pkg::US_PER_S;
            end
            ST_MYAW: begin
                w_mul_a = {1'b0, r_deg};
                w_mul_b = pmcg_pkg::US_PER_S;
            end
            ST_MACC: begin
                w_mul_a = {1'b0, w_sj};
                w_mul_b = pmcg_pkg::US_PER_S;
            end
            ST_MYAC: begin
                w_mul_a = {1'b0, w_yj};
                w_mul_b = pmcg_pkg::US_PER_S;
            end
            default: begin
                w_mul_a = 33'd0;
                w_mul_b = 35'd0;
            end
        endcase
    end

    // Divider operands; every product lands in the cycle after its multiply step.
    assign w_div_start = (r_state == ST_DSPDGO) || (r_state == ST_DYAWGO)
                         || (r_state == ST_DCRVGO) || (r_state == ST_DACCGO)
                         || (r_state == ST_DYACGO);
    assign w_div_num   = (r_state == ST_DCRVGO)
                         ? (64'(r_rad) << pmcg_pkg::FRAC_BITS) : w_prod[63:0];
    assign w_div_den   = (r_state == ST_DCRVGO) ? 48'(w_cden) : r_dt;
    assign w_sq_start  = (r_state == ST_SQGO);

    pmcg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    pmcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    pmcg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (r_sum),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_in_acc) n_state = ST_PREP;
            ST_PREP:   n_state = w_motion ? ST_MSQX : ST_DONE;
            ST_MSQX:   n_state = ST_MSQY;
            ST_MSQY:   n_state = ST_MRAD;
            ST_MRAD:   n_state = ST_SQGO;
            ST_SQGO:   n_state = ST_SQW;
            ST_SQW:    if (w_sq_done) n_state = ST_MSPD;
            ST_MSPD:   n_state = ST_DSPDGO;
            ST_DSPDGO: n_state = ST_DSPDW;
            ST_DSPDW:  if (w_div_stat.done) n_state = ST_MYAW;
            ST_MYAW:   n_state = ST_DYAWGO;
            ST_DYAWGO: n_state = ST_DYAWW;
            ST_DYAWW:  if (w_div_stat.done) n_state = ST_DCRVGO;
            ST_DCRVGO: n_state = ST_DCRVW;
            ST_DCRVW: begin
                if (w_div_stat.done) begin
                    n_state = (r_req || !r_has_hist) ? ST_DONE : ST_MACC;
                end
            end
            ST_MACC:   n_state = ST_DACCGO;
            ST_DACCGO: n_state = ST_DACCW;
            ST_DACCW:  if (w_div_stat.done) n_state = ST_MYAC;
            ST_MYAC:   n_state = ST_DYACGO;
            ST_DYACGO: n_state = ST_DYACW;
            ST_DYACW:  if (w_div_stat.done) n_state = ST_DONE;
            ST_DONE:   if (w_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control state, configuration and committed state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ov         <= 1'b0;
            r_has_last   <= 1'b0;
            r_has_hist   <= 1'b0;
            r_last_x     <= 32'd0;
            r_last_y     <= 32'd0;
            r_last_hdg   <= 16'd0;
            r_last_time  <= 48'd0;
            r_hist_spd   <= 32'd0;
            r_hist_yaw   <= 32'd0;
            r_hist_crv   <= 32'd0;
            r_max_speed  <= pmcg_pkg::RST_MAX_SPEED[31:0];
            r_max_accel  <= pmcg_pkg::RST_MAX_ACCEL[31:0];
            r_min_sjump  <= pmcg_pkg::RST_MIN_SJUMP[31:0];
            r_max_yrate  <= pmcg_pkg::RST_MAX_YRATE[31:0];
            r_max_yaccel <= pmcg_pkg::RST_MAX_YACCEL[31:0];
            r_min_yjump  <= pmcg_pkg::RST_MIN_YJUMP[31:0];
            r_max_cjump  <= pmcg_pkg::RST_MAX_CJUMP[31:0];
            r_min_cdist  <= pmcg_pkg::RST_MIN_CDIST[31:0];
        end else begin
            r_state <= n_state;

            if (w_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    pmcg_pkg::REG_MAX_SPEED:  r_max_speed  <= i_cfg_data;
                    pmcg_pkg::REG_MAX_ACCEL:  r_max_accel  <= i_cfg_data;
                    pmcg_pkg::REG_MIN_SJUMP:  r_min_sjump  <= i_cfg_data;
                    pmcg_pkg::REG_MAX_YRATE:  r_max_yrate  <= i_cfg_data;
                    pmcg_pkg::REG_MAX_YACCEL: r_max_yaccel <= i_cfg_data;
                    pmcg_pkg::REG_MIN_YJUMP:  r_min_yjump  <= i_cfg_data;
                    pmcg_pkg::REG_MAX_CJUMP:  r_max_cjump  <= i_cfg_data;
                    pmcg_pkg::REG_MIN_CDIST:  r_min_cdist  <= i_cfg_data;
                    default: ;
                endcase
            end

            // A valid commit records the pose; the motion sample goes into
            // history only when there was a pose to measure it from.
            if (w_load && w_commit_ok) begin
                r_last_x    <= r_x;
                r_last_y    <= r_y;
                r_last_hdg  <= r_hdg;
                r_last_time <= r_time;
                r_has_last  <= 1'b1;
                if (r_has_last) begin
                    r_hist_spd <= r_speed;
                    r_hist_yaw <= r_yaw;
                    r_hist_crv <= r_curv;
                    r_has_hist <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req   <= i_req_type;
            r_valid <= i_pose_valid;
            r_x     <= i_pos_x;
            r_y     <= i_pos_y;
            r_hdg   <= i_heading;
            r_time  <= i_time_us;
        end
        case (r_state)
            ST_PREP: begin
                r_half  <= w_half;
                r_bx    <= w_half ? w_ax[32:1] : w_ax[31:0];
                r_by    <= w_half ? w_ay[32:1] : w_ay[31:0];
                r_d     <= w_d;
                r_deg   <= w_deg64[31:0];
                r_dt    <= w_use_diff ? w_tdiff : pmcg_pkg::DT_MIN_US;
                r_speed <= 32'd0;
                r_yaw   <= 32'd0;
                r_curv  <= 32'd0;
            end
            ST_MSQY: r_sum <= w_prod[63:0];
            ST_MRAD: r_sum <= r_sum + w_prod[63:0];
            ST_SQGO: r_rad <= 32'(w_prod >> RAD_SHIFT);
            ST_SQW: begin
                if (w_sq_done) begin
                    r_ds <= r_half ? {w_root, 1'b0} : {1'b0, w_root};
                end
            end
            ST_DSPDW: if (w_div_stat.done) r_speed <= w_quot;
            ST_DYAWW: if (w_div_stat.done) r_yaw <= w_quot;
            ST_DCRVW: if (w_div_stat.done) r_curv <= w_quot;
            ST_DACCW: begin
                if (w_div_stat.done) begin
                    r_acc_gt <= w_div_stat.ovf || (w_quot > r_max_accel);
                end
            end
            ST_DYACW: begin
                if (w_div_stat.done) begin
                    r_yacc_gt <= w_div_stat.ovf || (w_quot > r_max_yaccel);
                end
            end
            default: ;
        endcase

        // Result assembly. Motion fields are zero unless a motion pass ran.
        if (w_load) begin
            r_o_spd <= w_motion ? r_speed : 32'd0;
            r_o_yaw <= w_motion ? r_yaw : 32'd0;
            r_o_crv <= w_motion ? r_curv : 32'd0;
            if (r_req) begin
                r_o_cont <= r_valid;
                r_o_rdy  <= w_motion;
            end else if (w_motion && r_has_hist) begin
                r_o_cont <= !w_bad;
                r_o_rdy  <= 1'b1;
            end else begin
                r_o_cont <= r_valid;
                r_o_rdy  <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_ov;
    assign o_continuous = r_o_cont;
    assign o_ready_res  = r_o_rdy;
    assign o_speed      = r_o_spd;
    assign o_yaw_rate   = r_o_yaw;
    assign o_curvature  = r_o_crv;

    // A motion sample is only ever stored on top of a committed pose.
    a_hist_needs_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_has_hist |-> r_has_last)
        else $error("history present without a committed pose");

    // An accepted beat always sends the sequencer off idle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_PREP))
        else $error("accepted beat did not start the sequencer");

    // A start of the shared divider is never directly followed by another start.
    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> !w_div_start)
        else $error("divider started on back-to-back cycles");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pose motion continuity gate.
module testbench;

    localparam logic [7:0] REG_UNUSED = 8'd8;
    localparam int NUM_REGS = 8;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_PER_PHASE = 425;

    typedef struct packed {
        logic        req_type;
        logic        pose_valid;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
        logic [47:0] time_us;
    } t_pose_beat;

    typedef struct packed {
        logic        continuous;
        logic        ready_res;
        logic [31:0] speed;
        logic [31:0] yaw_rate;
        logic [31:0] curvature;
    } t_gate_result;

    typedef struct {
        logic [63:0] ds;
        logic [63:0] deg;
        logic [63:0] speed;
        logic [63:0] yaw_rate;
        logic [63:0] curvature;
    } t_motion;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_req_type;
    logic        i_pose_valid;
    logic [31:0] i_pos_x;
    logic [31:0] i_pos_y;
    logic [15:0] i_heading;
    logic [47:0] i_time_us;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_continuous;
    logic        o_ready_res;
    logic [31:0] o_speed;
    logic [31:0] o_yaw_rate;
    logic [31:0] o_curvature;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    pose_motion_continuity_gate uut (.*);

    // Beats waiting to be driven, and the results predicted for accepted beats.
    t_pose_beat   pose_fifo[$];
    t_gate_result result_fifo[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_cnt = 0;
    int result_beats = 0;
    int hold_left = 0;
    bit hold_done = 0;
    int quiet_cycles = 0;

    // Predictor copy of the registers and of the gate state.
    logic [63:0] cfg_reg [NUM_REGS];
    logic [31:0] last_x, last_y;
    logic [15:0] last_hdg;
    logic [47:0] last_t;
    bit          has_pose, has_hist;
    logic [63:0] hist_speed, hist_yaw, hist_curv;

    // Track that the stimulus follows, so that most beats continue the motion.
    logic [31:0] trk_x, trk_y;
    logic [15:0] trk_h;
    logic [47:0] trk_t;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [63:0] sat32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function automatic logic [63:0] absdiff(logic [63:0] a, logic [63:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // Motion of a pose against the last committed one over time step dt.
    function automatic t_motion pose_motion(t_pose_beat b, logic [63:0] dt);
        t_motion m;
        longint sdx, sdy;
        logic [63:0] ax, ay, hx, hy, rad, dv;
        logic [15:0] d;
        logic [63:0] dw;
        sdx = longint'($signed(b.pos_x)) - longint'($signed(last_x));
        sdy = longint'($signed(b.pos_y)) - longint'($signed(last_y));
        ax = (sdx < 0) ? -sdx : sdx;
        ay = (sdy < 0) ? -sdy : sdy;
        if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
            hx = ax >> 1;
            hy = ay >> 1;
            m.ds = int_sqrt(hx * hx + hy * hy) << 1;
        end else begin
            m.ds = int_sqrt(ax * ax + ay * ay);
        end
        d = b.heading - last_hdg;
        dw = {48'd0, d};
        if (dw > 64'd32768) dw = 64'd65536 - dw;
        m.deg = ((dw * 64'd360) << pmcg_pkg::FRAC_BITS) >> 16;
        rad = (dw * 64'(pmcg_pkg::PI_Q33)) >> (48 - pmcg_pkg::FRAC_BITS);
        m.speed = sat32(m.ds * 64'(pmcg_pkg::US_PER_S) / dt);
        m.yaw_rate = sat32(m.deg * 64'(pmcg_pkg::US_PER_S) / dt);
        dv = (m.ds > cfg_reg[pmcg_pkg::REG_MIN_CDIST]) ? m.ds
                                                       : cfg_reg[pmcg_pkg::REG_MIN_CDIST];
        if (dv == 0) dv = 1;
        m.curvature = sat32((rad << pmcg_pkg::FRAC_BITS) / dv);
        return m;
    endfunction

    // Expected result of one accepted pose beat; valid commits update the state.
    function automatic t_gate_result gate_predict(t_pose_beat b);
        t_gate_result r;
        t_motion m;
        logic [63:0] dt, sj, yj, cj, acc, yacc;
        bit bad;
        r = '0;
        dt = 64'(pmcg_pkg::DT_MIN_US);
        if (b.req_type) begin
            r.continuous = b.pose_valid;
            if (!b.pose_valid) return r;
            if (has_pose) begin
                if (b.time_us > last_t && b.time_us - last_t > pmcg_pkg::DT_MIN_US)
                    dt = 64'(b.time_us - last_t);
                m = pose_motion(b, dt);
                hist_speed = m.speed;
                hist_yaw = m.yaw_rate;
                hist_curv = m.curvature;
                has_hist = 1;
                r.ready_res = 1'b1;
                r.speed = m.speed[31:0];
                r.yaw_rate = m.yaw_rate[31:0];
                r.curvature = m.curvature[31:0];
            end
            last_x = b.pos_x;
            last_y = b.pos_y;
            last_hdg = b.heading;
            last_t = b.time_us;
            has_pose = 1;
            return r;
        end
        if (!b.pose_valid) return r;
        r.continuous = 1'b1;
        if (!has_pose) return r;
        // A last time of zero means no usable time base, so the floor applies.
        if (last_t != 0 && b.time_us > last_t && b.time_us - last_t > pmcg_pkg::DT_MIN_US)
            dt = 64'(b.time_us - last_t);
        m = pose_motion(b, dt);
        r.speed = m.speed[31:0];
        r.yaw_rate = m.yaw_rate[31:0];
        r.curvature = m.curvature[31:0];
        if (!has_hist) return r;
        sj = absdiff(m.speed, hist_speed);
        yj = absdiff(m.yaw_rate, hist_yaw);
        cj = absdiff(m.curvature, hist_curv);
        acc = sj * 64'(pmcg_pkg::US_PER_S) / dt;
        yacc = yj * 64'(pmcg_pkg::US_PER_S) / dt;
        bad = (m.speed > cfg_reg[pmcg_pkg::REG_MAX_SPEED])
            || (acc > cfg_reg[pmcg_pkg::REG_MAX_ACCEL]
                && sj > cfg_reg[pmcg_pkg::REG_MIN_SJUMP])
            || (m.yaw_rate > cfg_reg[pmcg_pkg::REG_MAX_YRATE])
            || (yacc > cfg_reg[pmcg_pkg::REG_MAX_YACCEL]
                && yj > cfg_reg[pmcg_pkg::REG_MIN_YJUMP])
            || (cj > cfg_reg[pmcg_pkg::REG_MAX_CJUMP]
                && m.deg > pmcg_pkg::DEG_MIN && m.ds > pmcg_pkg::DS_MIN);
        r.continuous = !bad;
        r.ready_res = 1'b1;
        return r;
    endfunction

    // The driver offers the next queued beat once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                t_gate_result pred;
                pred = gate_predict(t_pose_beat'({i_req_type, i_pose_valid, i_pos_x,
                                                  i_pos_y, i_heading, i_time_us}));
                result_fifo = {result_fifo, pred};
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pose_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_pose_beat b;
                    b = pose_fifo[0];
                    pose_fifo.delete(0);
                    i_in_valid   <= 1'b1;
                    i_req_type   <= b.req_type;
                    i_pose_valid <= b.pose_valid;
                    i_pos_x      <= b.pos_x;
                    i_pos_y      <= b.pos_y;
                    i_heading    <= b.heading;
                    i_time_us    <= b.time_us;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver stalls at random, and once holds off long enough that the
    // gate fills up and stalls its input while beats keep coming.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && result_beats == 600) begin
            i_out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // The monitor checks each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_gate_result got, exp_r;
            got = {o_continuous, o_ready_res, o_speed, o_yaw_rate, o_curvature};
            result_beats <= result_beats + 1;
            if (result_fifo.size() == 0) begin
                mismatch_cnt = mismatch_cnt + 1;
                if (mismatch_cnt <= 10)
                    $display("unexpected result beat: %h", got);
            end else begin
                exp_r = result_fifo[0];
                result_fifo.delete(0);
                if (got !== exp_r) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= 10)
                        $display("%0d: cont %b/%b rdy %b/%b spd %h/%h yaw %h/%h crv %h/%h",
                                 result_beats, exp_r.continuous, got.continuous,
                                 exp_r.ready_res, got.ready_res, exp_r.speed, got.speed,
                                 exp_r.yaw_rate, got.yaw_rate, exp_r.curvature, got.curvature);
                end
            end
        end
    end

    // Watchdog: too long without any beat on any channel ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** pose_motion_continuity_gate: FAILED **");
            $finish;
        end
    end

    task automatic queue_pose(logic rq, logic pv, logic [31:0] x, logic [31:0] y,
                              logic [15:0] h, logic [47:0] t);
        t_pose_beat b;
        b = {rq, pv, x, y, h, t};
        pose_fifo = {pose_fifo, b};
    endtask

    task automatic cfg_write(logic [7:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx < NUM_REGS) cfg_reg[idx] = {32'd0, data};
        i_cfg_valid <= 1'b0;
    endtask

    // The sender pauses here until every predicted result has come back.
    task automatic wait_drained();
        while (pose_fifo.size() != 0 || result_fifo.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_step(int range);
        return 32'($urandom_range(2 * range)) - 32'(range);
    endfunction

    // One random beat: mostly poses that continue the track, some noise.
    task automatic queue_random_pose();
        t_pose_beat b;
        int sel, pick, range;
        sel = $urandom_range(99);
        if (sel < 10) begin
            b.pos_x = $urandom;
            b.pos_y = $urandom;
            b.heading = 16'($urandom);
            b.time_us = {$urandom, $urandom};
            b.req_type = $urandom_range(1);
            b.pose_valid = (sel < 7);
        end else begin
            pick = $urandom_range(3);
            range = (pick == 0) ? 0 : (pick == 1) ? 3000 : (pick == 2) ? 20000 : 200000;
            b.req_type = ($urandom_range(99) < 35);
            b.pose_valid = ($urandom_range(99) >= 4);
            b.pos_x = trk_x + rand_step(range);
            b.pos_y = trk_y + rand_step(range);
            b.heading = trk_h + ((pick == 3) ? 16'($urandom) : 16'(rand_step(1200)));
            pick = $urandom_range(99);
            if (pick < 5)
                b.time_us = trk_t + 48'($urandom_range(1500));
            else if (pick < 8)
                b.time_us = trk_t - 48'($urandom_range(200000));
            else
                b.time_us = trk_t + 48'($urandom_range(150000, 50000));
        end
        if (b.req_type && b.pose_valid) begin
            trk_x = b.pos_x;
            trk_y = b.pos_y;
            trk_h = b.heading;
            trk_t = b.time_us;
        end
        pose_fifo = {pose_fifo, b};
    endtask

    initial begin
        int ph, k, i;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = 1'b0;
        i_pose_valid = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_heading = '0;
        i_time_us = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cfg_reg[pmcg_pkg::REG_MAX_SPEED]  = pmcg_pkg::RST_MAX_SPEED;
        cfg_reg[pmcg_pkg::REG_MAX_ACCEL]  = pmcg_pkg::RST_MAX_ACCEL;
        cfg_reg[pmcg_pkg::REG_MIN_SJUMP]  = pmcg_pkg::RST_MIN_SJUMP;
        cfg_reg[pmcg_pkg::REG_MAX_YRATE]  = pmcg_pkg::RST_MAX_YRATE;
        cfg_reg[pmcg_pkg::REG_MAX_YACCEL] = pmcg_pkg::RST_MAX_YACCEL;
        cfg_reg[pmcg_pkg::REG_MIN_YJUMP]  = pmcg_pkg::RST_MIN_YJUMP;
        cfg_reg[pmcg_pkg::REG_MAX_CJUMP]  = pmcg_pkg::RST_MAX_CJUMP;
        cfg_reg[pmcg_pkg::REG_MIN_CDIST]  = pmcg_pkg::RST_MIN_CDIST;
        last_x = '0; last_y = '0; last_hdg = '0; last_t = '0;
        has_pose = 0; has_hist = 0;
        hist_speed = 0; hist_yaw = 0; hist_curv = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset register values.
        send_idle_pct = 36;
        recv_idle_pct = 47;
        queue_pose(1'b0, 1'b1, 32'd100, 32'd100, 16'd0, 48'd5000);    // no last pose
        queue_pose(1'b0, 1'b0, 32'd1, 32'd2, 16'd3, 48'd4);           // invalid evaluate
        queue_pose(1'b1, 1'b0, 32'd7, 32'd7, 16'd7, 48'd7);           // invalid commit
        queue_pose(1'b1, 1'b1, 32'd0, 32'd0, 16'd0, 48'd0);           // commit at time zero
        queue_pose(1'b0, 1'b1, 32'd5000, 32'd0, 16'd100, 48'd90000);  // zero last time
        queue_pose(1'b1, 1'b1, 32'd6000, 32'd0, 16'd100, 48'd100000); // first history
        queue_pose(1'b0, 1'b1, 32'd12000, 32'd0, 16'd200, 48'd200000);
        queue_pose(1'b0, 1'b1, 32'd6000, 32'd0, 16'd100, 48'd100500); // step under floor
        queue_pose(1'b0, 1'b1, 32'd6000, 32'd0, 16'd100, 48'd50000);  // time going back
        queue_pose(1'b0, 1'b1, 32'd6000, 32'd0, 16'd100, 48'hFFFF_FFFF_FFFF);
        queue_pose(1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'd32868, 48'd300000);
        queue_pose(1'b0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        queue_pose(1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 48'd300000);
        queue_pose(1'b0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 48'd400000);
        queue_pose(1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000, 16'd1, 48'd401000);
        queue_pose(1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 16'd32769, 48'd500000);
        queue_pose(1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000, 16'd1, 48'd400000);
        queue_pose(1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 16'd1, 48'd400000);
        queue_pose(1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_FFFF, 16'h8000, 48'd500000);
        queue_pose(1'b0, 1'b1, 32'h0000_0000, 32'hFFFF_0000, 16'h0000, 48'd600000);
        wait_drained();

        trk_x = '0; trk_y = '0; trk_h = '0; trk_t = 48'd1000000;
        for (ph = 1; ph <= 4; ph++) begin
            for (k = 0; k < NUM_REGS; k++) begin
                logic [31:0] v;
                case (ph)
                    1: v = 32'((cfg_reg[k] * $urandom_range(200, 50)) / 100);
                    2: v = 32'd0;
                    3: v = 32'hFFFF_FFFF;
                    default: v = $urandom_range(1, 0) ? $urandom : 32'($urandom_range(200000));
                endcase
                cfg_write(8'(k), v);
            end
            cfg_write(REG_UNUSED, $urandom);
            if (ph == 4) begin
                // Back near the reset values so the track stays mostly plausible.
                cfg_write(pmcg_pkg::REG_MAX_SPEED, pmcg_pkg::RST_MAX_SPEED[31:0]);
                cfg_write(pmcg_pkg::REG_MAX_YRATE, pmcg_pkg::RST_MAX_YRATE[31:0]);
            end
            send_idle_pct = (ph == 1) ? 36 : (ph == 2) ? 47 : 0;
            recv_idle_pct = (ph == 1) ? 47 : (ph == 2) ? 36 : 0;
            for (i = 0; i < RANDOM_PER_PHASE; i++) queue_random_pose();
            wait_drained();
        end

        if (mismatch_cnt == 0 && result_fifo.size() == 0) begin
            $display("** pose_motion_continuity_gate: PASSED **");
        end else begin
            $display("** pose_motion_continuity_gate: FAILED **");
        end
        $finish;
    end

endmodule

FILE: pose_motion_continuity_gate.f
src/pmcg_pkg.sv
src/pmcg_mul.sv
src/pmcg_div.sv
src/pmcg_sqrt.sv
src/pose_motion_continuity_gate.sv
dv/testbench.sv
